// File: src/u8bd_pkg.sv
package u8bd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned LenW   = 3;
  localparam int unsigned CountW = 2;

  // byte classes, seen on bits 7:6
  localparam logic [1:0] CLS_CONT = 2'b10;
  localparam logic [1:0] CLS_LEAD = 2'b11;

  // length codes
  localparam logic [LenW-1:0] LEN_1 = 3'd1;
  localparam logic [LenW-1:0] LEN_2 = 3'd2;
  localparam logic [LenW-1:0] LEN_3 = 3'd3;
  localparam logic [LenW-1:0] LEN_4 = 3'd4;

  localparam logic [CountW-1:0] SEEN_IDLE = 2'd0;
  localparam logic [CountW-1:0] SEEN_ONE  = 2'd1;
  localparam logic [CountW-1:0] SEEN_TWO  = 2'd2;
  localparam logic [CountW-1:0] SEEN_MAX  = 2'd3;

  typedef struct packed {
    logic [CountW-1:0] bytes_seen;
    logic              reverse_mode;
    logic [LenW-1:0]   target_length;
    logic [CodeW-1:0]  accumulator;
  } dec_state_t;

  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic [LenW-1:0]  char_length;
    logic             was_reversed;
  } char_t;

  // payload mask of a lead byte for a sequence of the given length
  function automatic logic [ByteW-1:0] lead_mask(input logic [LenW-1:0] len);
    logic [ByteW-1:0] m;
    begin
      if (len == LEN_2) begin
        m = 8'h1F;
      end else if (len == LEN_3) begin
        m = 8'h0F;
      end else begin
        m = 8'h07;
      end
      return m;
    end
  endfunction

endpackage

// File: src/u8bd_in_if.sv
interface u8bd_in_if;
  logic                        valid;
  logic                        ready;
  logic [u8bd_pkg::ByteW-1:0]  byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

// File: src/u8bd_out_if.sv
interface u8bd_out_if;
  logic                        valid;
  logic                        ready;
  logic [u8bd_pkg::CodeW-1:0]  code_point;
  logic [u8bd_pkg::LenW-1:0]   char_length;
  logic                        was_reversed;

  modport source (output valid, output code_point, output char_length,
                  output was_reversed, input ready);
  modport sink   (input valid, input code_point, input char_length,
                  input was_reversed, output ready);
endinterface

// File: src/u8bd_step.sv
// Next-state and result for one byte.
module u8bd_step (
  input  u8bd_pkg::dec_state_t        cur,
  input  logic [u8bd_pkg::ByteW-1:0]  byte_in,
  output u8bd_pkg::dec_state_t        nxt,
  output logic                        emit,
  output u8bd_pkg::char_t             res
);

  always_comb begin
    logic [1:0]                   sel;
    logic [u8bd_pkg::LenW-1:0]    len;
    logic [u8bd_pkg::CodeW-1:0]   fwd_acc;
    logic [u8bd_pkg::CodeW-1:0]   lead_bits;
    logic [u8bd_pkg::CodeW-1:0]   cont_bits;
    logic [u8bd_pkg::LenW-1:0]    seen_p1;
    logic [u8bd_pkg::ByteW-1:0]   lead_pay;

    nxt  = cur;
    emit = 1'b0;
    res  = '{code_point: '0, char_length: '0, was_reversed: 1'b0};

    sel       = byte_in[5:4];
    len       = (sel == 2'd0) ? u8bd_pkg::LEN_2 : ({1'b0, sel} + 3'd1);
    seen_p1   = {1'b0, cur.bytes_seen} + 3'd1;
    fwd_acc   = {cur.accumulator[u8bd_pkg::CodeW-7:0], byte_in[5:0]};
    lead_pay  = byte_in & u8bd_pkg::lead_mask(seen_p1);
    lead_bits = '0;
    cont_bits = '0;

    // place this byte's bits above those already gathered (reversed order)
    unique case (cur.bytes_seen)
      u8bd_pkg::SEEN_ONE: begin
        lead_bits = {8'd0, lead_pay, 5'd0} << 1;
        cont_bits = {9'd0, byte_in[5:0], 6'd0};
      end
      u8bd_pkg::SEEN_TWO: begin
        lead_bits = {1'b0, lead_pay, 12'd0};
        cont_bits = {3'd0, byte_in[5:0], 12'd0};
      end
      u8bd_pkg::SEEN_MAX: begin
        lead_bits = {lead_pay[2:0], 18'd0};
        cont_bits = {byte_in[2:0], 18'd0};
      end
      default: begin
        lead_bits = {13'd0, lead_pay};
        cont_bits = {15'd0, byte_in[5:0]};
      end
    endcase

    if (cur.bytes_seen == u8bd_pkg::SEEN_IDLE) begin
      if (!byte_in[7]) begin
        emit = 1'b1;
        res  = '{code_point: {13'd0, byte_in}, char_length: u8bd_pkg::LEN_1,
                 was_reversed: 1'b0};
      end else if (byte_in[7:6] == u8bd_pkg::CLS_LEAD) begin
        nxt.bytes_seen    = u8bd_pkg::SEEN_ONE;
        nxt.reverse_mode  = 1'b0;
        nxt.target_length = len;
        nxt.accumulator   = {13'd0, byte_in & u8bd_pkg::lead_mask(len)};
      end else begin
        nxt.bytes_seen    = u8bd_pkg::SEEN_ONE;
        nxt.reverse_mode  = 1'b1;
        nxt.target_length = '0;
        nxt.accumulator   = {15'd0, byte_in[5:0]};
      end
    end else if (!cur.reverse_mode) begin
      if (seen_p1 >= cur.target_length) begin
        emit = 1'b1;
        res  = '{code_point: fwd_acc, char_length: cur.target_length,
                 was_reversed: 1'b0};
        nxt  = '0;
      end else begin
        nxt.bytes_seen  = seen_p1[u8bd_pkg::CountW-1:0];
        nxt.accumulator = fwd_acc;
      end
    end else begin
      if (byte_in[6] || cur.bytes_seen == u8bd_pkg::SEEN_MAX) begin
        emit = 1'b1;
        res  = '{code_point: cur.accumulator | lead_bits, char_length: seen_p1,
                 was_reversed: 1'b1};
        nxt  = '0;
      end else begin
        nxt.bytes_seen  = seen_p1[u8bd_pkg::CountW-1:0];
        nxt.accumulator = cur.accumulator | cont_bits;
      end
    end
  end

endmodule

// File: src/utf8_bidirectional_decoder.sv
// Channel  | Dir | Payload                                  | Request
// ---------+-----+------------------------------------------+-------------------------
// in_chan  | in  | byte_in[7:0]                             | one raw byte
// out_chan | out | code_point[20:0], char_length[2:0],      | one decoded character
//          |     | was_reversed                             |
//
// One byte per cycle. The decode of a byte is a single pass of mask/shift
// logic from the state registers into the result register, so a character
// is offered on out_chan the cycle after its last byte is taken.
// rst_n is synchronous, active low; it returns the decoder to idle and
// empties the result register. A stalled result holds in out_chan; input
// keeps flowing while the result register is empty or being drained.
module utf8_bidirectional_decoder (
  input  logic             clk,
  input  logic             rst_n,
  u8bd_in_if.sink          in_chan,
  u8bd_out_if.source       out_chan
);

  u8bd_pkg::dec_state_t state_r, state_nxt;
  u8bd_pkg::char_t      res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 step_emit;
  logic                 in_take;

  // Result register is free if empty or being taken this cycle.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_take       = in_chan.valid && in_chan.ready;

  u8bd_step u_step (
    .cur     (state_r),
    .byte_in (in_chan.byte_in),
    .nxt     (state_nxt),
    .emit    (step_emit),
    .res     (res_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_take && step_emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // decoder state: only advances on an accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_take) begin
        state_r <= state_nxt;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take && step_emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.code_point   = res_r.code_point;
  assign out_chan.char_length  = res_r.char_length;
  assign out_chan.was_reversed = res_r.was_reversed;

endmodule
